/* hw/rtl/ir_pulse_distance_transmitter_defines.svh */
// Assertion macros for the IR pulse-distance transmitter.
// No dependencies; included by the RTL files that carry assertions.
`ifndef IR_PULSE_DISTANCE_TRANSMITTER_DEFINES_SVH
`define IR_PULSE_DISTANCE_TRANSMITTER_DEFINES_SVH

`ifndef SYNTH
// Clocked assertion, switched off while reset is high
`define IRPDT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("irpdt assertion failed");
// Clocked assertion that also holds during reset
`define IRPDT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("irpdt assertion failed");
`else
`define IRPDT_ASSERT(label, clk, rst, prop)
`define IRPDT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* hw/rtl/irpdt_pkg.sv */
// Package for the IR pulse-distance transmitter: payload and config types,
// phase codes, register indexes and sizing constants. No dependencies.
`timescale 1ns / 1ps

package irpdt_pkg;

   // Frame buffer sizing
   localparam int MAX_BYTES   = 16;
   localparam int BYTE_CNT_W  = $clog2(MAX_BYTES + 1);
   localparam int BYTE_ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

   localparam int TICK_W  = 16;
   localparam int REPS_W  = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Reset values of the timing registers
   localparam logic [TICK_W-1:0] RST_HDR_MARK  = 16'd5000;
   localparam logic [TICK_W-1:0] RST_HDR_SPACE = 16'd5000;
   localparam logic [TICK_W-1:0] RST_BIT_MARK  = 16'd500;
   localparam logic [TICK_W-1:0] RST_ONE_SPACE = 16'd1500;
   localparam logic [TICK_W-1:0] RST_ZERO_SPACE = 16'd500;
   localparam logic [TICK_W-1:0] RST_TRL_SPACE = 16'd5000;
   localparam logic [REPS_W-1:0] RST_REPEAT    = 4'd2;

   // Request action codes
   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_LOAD = 1'b1
   } action_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HDR_MARK   = 3'd0,
      REG_HDR_SPACE  = 3'd1,
      REG_BIT_MARK   = 3'd2,
      REG_ONE_SPACE  = 3'd3,
      REG_ZERO_SPACE = 3'd4,
      REG_TRL_SPACE  = 3'd5,
      REG_REPEAT     = 3'd6
   } reg_index_type;

   // Transmit phases, one-hot
   typedef enum logic [6:0] {
      PH_IDLE      = 7'b000_0001,
      PH_HDR_MARK  = 7'b000_0010,
      PH_HDR_SPACE = 7'b000_0100,
      PH_BIT_MARK  = 7'b000_1000,
      PH_BIT_SPACE = 7'b001_0000,
      PH_TRL_MARK  = 7'b010_0000,
      PH_TRL_SPACE = 7'b100_0000
   } phase_type;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic carrier_on;
      logic busy_res;
      logic frame_done;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] header_mark_ticks;
      logic [TICK_W-1:0] header_space_ticks;
      logic [TICK_W-1:0] bit_mark_ticks;
      logic [TICK_W-1:0] one_space_ticks;
      logic [TICK_W-1:0] zero_space_ticks;
      logic [TICK_W-1:0] trailer_space_ticks;
      logic [REPS_W-1:0] repeat_count;
   } cfg_type;

   // Frame buffer write port
   typedef struct packed {
      logic                   en;
      logic [BYTE_ADDR_W-1:0] addr;
      logic [7:0]             data;
   } store_wr_type;

endpackage

/* hw/rtl/irpdt_csr.sv */
// Timing and repeat configuration registers of the IR transmitter.
// Depends on irpdt_pkg.
`timescale 1ns / 1ps

module irpdt_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [irpdt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [irpdt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output irpdt_pkg::cfg_type                  cfg
);

   irpdt_pkg::cfg_type cfg_ff, cfg_in;

   // Register decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            irpdt_pkg::REG_HDR_MARK:   cfg_in.header_mark_ticks   = csr_wdata;
            irpdt_pkg::REG_HDR_SPACE:  cfg_in.header_space_ticks  = csr_wdata;
            irpdt_pkg::REG_BIT_MARK:   cfg_in.bit_mark_ticks      = csr_wdata;
            irpdt_pkg::REG_ONE_SPACE:  cfg_in.one_space_ticks     = csr_wdata;
            irpdt_pkg::REG_ZERO_SPACE: cfg_in.zero_space_ticks    = csr_wdata;
            irpdt_pkg::REG_TRL_SPACE:  cfg_in.trailer_space_ticks = csr_wdata;
            irpdt_pkg::REG_REPEAT:
               cfg_in.repeat_count = csr_wdata[irpdt_pkg::REPS_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_mark_ticks   <= irpdt_pkg::RST_HDR_MARK;
         cfg_ff.header_space_ticks  <= irpdt_pkg::RST_HDR_SPACE;
         cfg_ff.bit_mark_ticks      <= irpdt_pkg::RST_BIT_MARK;
         cfg_ff.one_space_ticks     <= irpdt_pkg::RST_ONE_SPACE;
         cfg_ff.zero_space_ticks    <= irpdt_pkg::RST_ZERO_SPACE;
         cfg_ff.trailer_space_ticks <= irpdt_pkg::RST_TRL_SPACE;
         cfg_ff.repeat_count        <= irpdt_pkg::RST_REPEAT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hw/rtl/irpdt_store.sv */
// Frame byte buffer: one write port, one registered read port.
// Depends on irpdt_pkg.
`timescale 1ns / 1ps

module irpdt_store (
   input  logic                                  clock,
   input  irpdt_pkg::store_wr_type               wr,
   input  logic [irpdt_pkg::BYTE_ADDR_W-1:0]     rd_addr,
   output logic [7:0]                            rd_data
);

   // Contents are undefined until loaded; only bytes of the current frame are read
   logic [7:0] mem_ff [irpdt_pkg::MAX_BYTES];
   logic [7:0] rd_data_ff;

   // Write on load, read every cycle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/irpdt_seq.sv */
// Frame sequencer: phase state, countdown, bit/byte/pass counters and the
// per-request result. Depends on irpdt_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "ir_pulse_distance_transmitter_defines.svh"

module irpdt_seq (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  irpdt_pkg::req_type                    req,
   input  irpdt_pkg::cfg_type                    cfg,
   input  logic [7:0]                            rd_byte,
   output logic [irpdt_pkg::BYTE_ADDR_W-1:0]     rd_addr,
   output irpdt_pkg::store_wr_type               wr,
   output irpdt_pkg::rsp_type                    res
);

   localparam int CW = irpdt_pkg::BYTE_CNT_W;

   irpdt_pkg::phase_type          phase_ff, phase_in;
   logic [CW-1:0]                 byte_total_ff, byte_total_in;
   logic [CW-1:0]                 byte_pos_ff, byte_pos_in;
   logic [2:0]                    bit_pos_ff, bit_pos_in;
   logic [irpdt_pkg::REPS_W-1:0]  passes_ff, passes_in;
   logic [irpdt_pkg::TICK_W-1:0]  tick_ff, tick_in;

   logic                          is_idle;
   logic                          cur_bit;
   logic [CW-1:0]                 byte_pos_nx;
   logic [2:0]                    bit_pos_nx;
   logic [irpdt_pkg::REPS_W-1:0]  passes_nx;
   logic [irpdt_pkg::REPS_W-1:0]  reps;

   assign is_idle = (phase_ff == irpdt_pkg::PH_IDLE);
   // Buffer read runs on the position being loaded, so the registered byte
   // always matches byte_pos_ff; a bit mark lasts at least one request
   assign rd_addr = step ? byte_pos_in[irpdt_pkg::BYTE_ADDR_W-1:0]
                         : byte_pos_ff[irpdt_pkg::BYTE_ADDR_W-1:0];
   // MSB first
   assign cur_bit = rd_byte[3'd7 - bit_pos_ff];

   // Bit and byte stepping at the end of a bit space
   always_comb begin
      if (bit_pos_ff == 3'd7) begin
         bit_pos_nx  = 3'd0;
         byte_pos_nx = byte_pos_ff + CW'(1);
      end else begin
         bit_pos_nx  = bit_pos_ff + 3'd1;
         byte_pos_nx = byte_pos_ff;
      end
   end

   // Pass counting; a zero repeat count sends once
   assign passes_nx = passes_ff + irpdt_pkg::REPS_W'(1);
   assign reps = (cfg.repeat_count == '0) ? irpdt_pkg::REPS_W'(1) : cfg.repeat_count;

   // Next state and result for one request
   always_comb begin
      phase_in      = phase_ff;
      byte_total_in = byte_total_ff;
      byte_pos_in   = byte_pos_ff;
      bit_pos_in    = bit_pos_ff;
      passes_in     = passes_ff;
      tick_in       = tick_ff;
      wr.en         = 1'b0;
      wr.addr       = byte_total_ff[irpdt_pkg::BYTE_ADDR_W-1:0];
      wr.data       = req.data_byte;
      res           = '0;

      if (req.action == irpdt_pkg::ACT_LOAD) begin
         // Loads are ignored while a frame is going out
         if (is_idle) begin
            if (byte_total_ff < CW'(irpdt_pkg::MAX_BYTES)) begin
               wr.en         = step;
               byte_total_in = byte_total_ff + CW'(1);
            end
            if (req.last_byte) begin
               passes_in   = '0;
               byte_pos_in = '0;
               bit_pos_in  = '0;
               phase_in    = irpdt_pkg::PH_HDR_MARK;
               tick_in     = cfg.header_mark_ticks;
            end
         end
         res.busy_res = (phase_in != irpdt_pkg::PH_IDLE);
      end else if (!is_idle) begin
         res.busy_res   = 1'b1;
         res.carrier_on = (phase_ff == irpdt_pkg::PH_HDR_MARK) ||
                          (phase_ff == irpdt_pkg::PH_BIT_MARK) ||
                          (phase_ff == irpdt_pkg::PH_TRL_MARK);
         if (tick_ff > irpdt_pkg::TICK_W'(1)) begin
            tick_in = tick_ff - irpdt_pkg::TICK_W'(1);
         end else begin
            unique case (phase_ff)
               irpdt_pkg::PH_HDR_MARK: begin
                  phase_in = irpdt_pkg::PH_HDR_SPACE;
                  tick_in  = cfg.header_space_ticks;
               end
               irpdt_pkg::PH_HDR_SPACE: begin
                  byte_pos_in = '0;
                  bit_pos_in  = '0;
                  // Empty frame goes straight to the trailer
                  phase_in = (byte_total_ff == '0) ? irpdt_pkg::PH_TRL_MARK
                                                   : irpdt_pkg::PH_BIT_MARK;
                  tick_in  = cfg.bit_mark_ticks;
               end
               irpdt_pkg::PH_BIT_MARK: begin
                  phase_in = irpdt_pkg::PH_BIT_SPACE;
                  tick_in  = cur_bit ? cfg.one_space_ticks : cfg.zero_space_ticks;
               end
               irpdt_pkg::PH_BIT_SPACE: begin
                  bit_pos_in  = bit_pos_nx;
                  byte_pos_in = byte_pos_nx;
                  phase_in = (byte_pos_nx >= byte_total_ff) ? irpdt_pkg::PH_TRL_MARK
                                                            : irpdt_pkg::PH_BIT_MARK;
                  tick_in  = cfg.bit_mark_ticks;
               end
               irpdt_pkg::PH_TRL_MARK: begin
                  phase_in = irpdt_pkg::PH_TRL_SPACE;
                  tick_in  = cfg.trailer_space_ticks;
               end
               irpdt_pkg::PH_TRL_SPACE: begin
                  if (passes_nx >= reps) begin
                     // Final pass: back to idle with an empty buffer
                     phase_in       = irpdt_pkg::PH_IDLE;
                     tick_in        = '0;
                     byte_total_in  = '0;
                     byte_pos_in    = '0;
                     bit_pos_in     = '0;
                     passes_in      = '0;
                     res.frame_done = 1'b1;
                  end else begin
                     passes_in = passes_nx;
                     phase_in  = irpdt_pkg::PH_HDR_MARK;
                     tick_in   = cfg.header_mark_ticks;
                  end
               end
               default: phase_in = irpdt_pkg::PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= irpdt_pkg::PH_IDLE;
         byte_total_ff <= '0;
         byte_pos_ff   <= '0;
         bit_pos_ff    <= '0;
         passes_ff     <= '0;
         tick_ff       <= '0;
      end else if (step) begin
         phase_ff      <= phase_in;
         byte_total_ff <= byte_total_in;
         byte_pos_ff   <= byte_pos_in;
         bit_pos_ff    <= bit_pos_in;
         passes_ff     <= passes_in;
         tick_ff       <= tick_in;
      end
   end

   // Buffer count never passes its depth
   `IRPDT_ASSERT(a_total_in_range, clock, reset, byte_total_ff <= CW'(irpdt_pkg::MAX_BYTES))
   // While a bit is on the line it points at a loaded byte
   `IRPDT_ASSERT(a_bit_in_frame, clock, reset, ((phase_ff == irpdt_pkg::PH_BIT_MARK) || (phase_ff == irpdt_pkg::PH_BIT_SPACE)) |-> (byte_pos_ff < byte_total_ff))
   // A load during transmission leaves the buffer untouched
   `IRPDT_ASSERT(a_load_ignored, clock, reset, (step && req.action && !is_idle) |=> $stable(byte_total_ff))
   // Finishing the last pass lands in idle with the buffer emptied
   `IRPDT_ASSERT(a_done_to_idle, clock, reset, (step && res.frame_done) |=> (is_idle && (byte_total_ff == '0)))

endmodule

/* hw/rtl/ir_pulse_distance_transmitter.sv */
// Top level of the IR pulse-distance transmitter: request/response handshake,
// result register and the instances. Depends on irpdt_pkg, irpdt_csr,
// irpdt_store and irpdt_seq.
//
// Usage:
//  - Request channel (req_valid/req_ready/req_data): each request is either one
//    time tick or one frame byte load. A load flagged last_byte starts sending.
//  - Response channel (rsp_valid/rsp_ready/rsp_data): exactly one response per
//    request, in order: carrier enable for that tick, busy flag and a done flag
//    on the tick that ends the final repetition.
//  - Config port (csr_we/csr_index/csr_wdata): timing and repeat registers, to be
//    written only while the block is idle; the block itself does not enforce this.
//  - Latency: a response is valid the cycle after its request is taken.
//  - Throughput: one request per cycle unless the receiver stalls; the countdown
//    and phase update of a tick complete in the accepting cycle.
//  - A single result register separates the channels; req_ready stays high
//    while that register is empty or being drained, so a stalled receiver
//    holds at most one response and back-pressures the request side.
//  - Reset (synchronous): idle phase, empty buffer, registers at defaults.
`timescale 1ns / 1ps

module ir_pulse_distance_transmitter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  irpdt_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output irpdt_pkg::rsp_type                 rsp_data,
   input  logic                               csr_we,
   input  logic [irpdt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [irpdt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   irpdt_pkg::cfg_type                      cfg;
   irpdt_pkg::store_wr_type                 wr;
   irpdt_pkg::rsp_type                      res;
   logic [irpdt_pkg::BYTE_ADDR_W-1:0]       rd_addr;
   logic [7:0]                              rd_byte;
   logic                                    step;

   logic                                    rsp_valid_ff, rsp_valid_in;
   irpdt_pkg::rsp_type                      rsp_data_ff, rsp_data_in;

   // Handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   irpdt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   irpdt_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_byte)
   );

   irpdt_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .req     (req_data),
      .cfg     (cfg),
      .rd_byte (rd_byte),
      .rd_addr (rd_addr),
      .wr      (wr),
      .res     (res)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
